>>> sv/spq_pkg.sv
// spq_pkg: widths, action codes and cell control type of the severity priority queue
// no dependencies; used by the channel interfaces, the cell and the top level
package spq_pkg;

    localparam int SEV_W    = 4;
    localparam int IN_TAG_W = 16;
    localparam int FILL_W   = 7;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef struct packed {
        logic load_new;
        logic from_left;
        logic from_right;
    } t_cell_ctl;

endpackage

>>> sv/spq_if.sv
// spq_in_if and spq_out_if: valid/ready channels of the severity priority queue
// depends on spq_pkg for field widths
interface spq_in_if import spq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic [SEV_W-1:0]    severity;
    logic [IN_TAG_W-1:0] message_tag;

    modport source (output valid, action, severity, message_tag, input ready);
    modport sink   (input valid, action, severity, message_tag, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IN_TAG_W-1:0] out_tag;
    logic [SEV_W-1:0]    out_severity;
    logic                was_empty;
    logic                push_dropped;
    logic [FILL_W-1:0]   fill_count;

    modport source (output valid, out_tag, out_severity, was_empty, push_dropped, fill_count,
                    input ready);
    modport sink   (input valid, out_tag, out_severity, was_empty, push_dropped, fill_count,
                    output ready);
endinterface

>>> sv/severity_priority_queue.sv
// severity_priority_queue: bounded max-priority queue of alarms, top level
// depends on spq_pkg, spq_in_if, spq_out_if and spq_cell
//
// Input channel i_in carries one beat per command: action push (severity and
// message tag) or pop. Output channel o_out returns exactly one beat per
// command: the popped tag and severity, the empty flag of a pop on an empty
// queue, the drop flag of a push on a full queue, and the fill count after it.
// The store is a chain of CAPACITY cells kept sorted by severity, highest at
// the head, equal severities in arrival order. A push compares in every cell
// at once and the cells behind the insert point shift one place back; a pop
// takes the head and every cell shifts one place forward.
// The result is registered and is valid in the cycle after its input beat; one command is taken per
// cycle while the output side keeps up, as the chain shifts at the edge that registers each result.
// When the receiver stalls, the result stays in the output register and
// i_in.ready drops until it is taken.
// Reset empties the queue; cell contents are not cleared, the entry count
// marks which cells hold alarms.
module severity_priority_queue import spq_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    logic [IN_TAG_W-1:0] r_out_tag;
    logic [SEV_W-1:0]    r_out_sev;
    logic                r_out_empty;
    logic                r_out_drop;
    logic [FILL_W-1:0]   r_out_fill;

    logic [SEV_W-1:0]    w_sev [CAPACITY];
    logic [TAG_BITS-1:0] w_tag [CAPACITY];
    logic                w_gt  [CAPACITY];

    logic                accept;
    logic                is_full;
    logic                is_empty;
    logic                push_ok;
    logic                pop_ok;
    logic [TAG_BITS-1:0] new_tag;
    logic [31:0]         in_tag32;
    logic [31:0]         head_tag32;
    logic [31:0]         fill32;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign is_full    = (r_count == CNT_W'(CAPACITY));
    assign is_empty   = (r_count == '0);
    assign push_ok    = accept && (i_in.action == ACT_PUSH) && !is_full;
    assign pop_ok     = accept && (i_in.action == ACT_POP) && !is_empty;

    assign in_tag32   = 32'(i_in.message_tag);
    assign new_tag    = in_tag32[TAG_BITS-1:0];
    assign head_tag32 = 32'(w_tag[0]);

    always_comb begin
        n_count = r_count;
        if (push_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    assign fill32 = 32'(n_count);

    // sorted chain
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_cell_ctl           ctl;
        logic                gt_prev;
        logic                occ;
        logic [SEV_W-1:0]    left_sev;
        logic [TAG_BITS-1:0] left_tag;
        logic [SEV_W-1:0]    right_sev;
        logic [TAG_BITS-1:0] right_tag;

        if (gi == 0) begin : g_head
            assign gt_prev  = 1'b0;
            assign left_sev = '0;
            assign left_tag = '0;
        end else begin : g_body
            assign gt_prev  = w_gt[gi-1];
            assign left_sev = w_sev[gi-1];
            assign left_tag = w_tag[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign right_sev = '0;
            assign right_tag = '0;
        end else begin : g_inner
            assign right_sev = w_sev[gi+1];
            assign right_tag = w_tag[gi+1];
        end

        assign occ            = (CNT_W'(gi) < r_count);
        assign ctl.load_new   = push_ok && w_gt[gi] && !gt_prev;
        assign ctl.from_left  = push_ok && w_gt[gi] && gt_prev;
        assign ctl.from_right = pop_ok;

        spq_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occ       (occ),
            .i_new_sev   (i_in.severity),
            .i_new_tag   (new_tag),
            .i_left_sev  (left_sev),
            .i_left_tag  (left_tag),
            .i_right_sev (right_sev),
            .i_right_tag (right_tag),
            .o_sev       (w_sev[gi]),
            .o_tag       (w_tag[gi]),
            .o_gt        (w_gt[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_tag   <= pop_ok ? head_tag32[IN_TAG_W-1:0] : '0;
            r_out_sev   <= pop_ok ? w_sev[0] : '0;
            r_out_empty <= (i_in.action == ACT_POP) && is_empty;
            r_out_drop  <= (i_in.action == ACT_PUSH) && is_full;
            r_out_fill  <= fill32[FILL_W-1:0];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_tag      = r_out_tag;
    assign o_out.out_severity = r_out_sev;
    assign o_out.was_empty    = r_out_empty;
    assign o_out.push_dropped = r_out_drop;
    assign o_out.fill_count   = r_out_fill;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_sev[0] >= w_sev[1]))
        else $error("head cell not the most severe");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_ok |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted push did not grow the queue");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_empty && r_out_drop))
        else $error("empty and drop flags both set");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while a result is stalled");

endmodule

>>> sv/spq_cell.sv
// spq_cell: one slot of the sorted chain, holds a severity and a tag
// depends on spq_pkg; loads the new alarm or a neighbor's entry when its control asks, else holds
module spq_cell import spq_pkg::*; #(
    parameter int TAG_BITS = 16
) (
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic                i_occ,
    input  logic [SEV_W-1:0]    i_new_sev,
    input  logic [TAG_BITS-1:0] i_new_tag,
    input  logic [SEV_W-1:0]    i_left_sev,
    input  logic [TAG_BITS-1:0] i_left_tag,
    input  logic [SEV_W-1:0]    i_right_sev,
    input  logic [TAG_BITS-1:0] i_right_tag,
    output logic [SEV_W-1:0]    o_sev,
    output logic [TAG_BITS-1:0] o_tag,
    output logic                o_gt
);

    logic [SEV_W-1:0]    r_sev;
    logic [TAG_BITS-1:0] r_tag;

    // new alarm goes ahead of this slot
    assign o_gt  = !i_occ || (r_sev < i_new_sev);
    assign o_sev = r_sev;
    assign o_tag = r_tag;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_new) begin
            r_sev <= i_new_sev;
            r_tag <= i_new_tag;
        end else if (i_ctl.from_left) begin
            r_sev <= i_left_sev;
            r_tag <= i_left_tag;
        end else if (i_ctl.from_right) begin
            r_sev <= i_right_sev;
            r_tag <= i_right_tag;
        end
    end

endmodule

>>> bench/tb_severity_priority_queue.sv
// tb_severity_priority_queue: self-checking bench for the severity priority queue
// depends on spq_pkg, spq_in_if, spq_out_if and severity_priority_queue
// directed table first, then fill/drain/mixed phases checked against a sorted-chain model
module tb_severity_priority_queue;
    import spq_pkg::*;

    localparam int QUEUE_CAP  = 64;
    localparam int TAG_WIDTH  = 16;
    localparam int IDLE_PCT   = 30;
    localparam int RAND_ITEMS = 1250;
    localparam int DRAIN_MAX  = 20000;

    typedef struct packed {
        logic [IN_TAG_W-1:0] tag;
        logic [SEV_W-1:0]    sev;
        logic                empty;
        logic                dropped;
        logic [FILL_W-1:0]   fill;
    } alarm_result_t;

    typedef struct packed {
        logic [SEV_W-1:0]    sev;
        logic [IN_TAG_W-1:0] tag;
    } alarm_cell_t;

    typedef struct packed {
        logic                act;
        logic [SEV_W-1:0]    sev;
        logic [IN_TAG_W-1:0] tag;
        logic                has_typed;
        alarm_result_t       typed;
    } stim_row_t;

    localparam alarm_result_t NO_TYPED = '0;

    logic i_clk;
    logic i_rst_n;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    severity_priority_queue #(
        .CAPACITY(QUEUE_CAP),
        .TAG_BITS(TAG_WIDTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    alarm_cell_t   alarm_chain[$];
    alarm_result_t pending_results[$];
    logic          calm;
    logic          cur_has_typed;
    alarm_result_t cur_typed;
    int            err_count;
    int            beats_in;
    int            beats_out;
    int            pops_hit;
    int            pops_empty;
    int            push_drops;
    int            peak_fill;

    // pop empty, extremes of severity and tag, equal severities, severity 0 and above 10
    stim_row_t dir_table [0:21] = '{
        '{ACT_POP,  4'd0,  16'h0000, 1'b1, '{16'h0000, 4'd0,  1'b1, 1'b0, 7'd0}},
        '{ACT_PUSH, 4'd10, 16'hFFFF, 1'b1, '{16'h0000, 4'd0,  1'b0, 1'b0, 7'd1}},
        '{ACT_PUSH, 4'd1,  16'h0000, 1'b1, '{16'h0000, 4'd0,  1'b0, 1'b0, 7'd2}},
        '{ACT_PUSH, 4'd0,  16'h1234, 1'b1, '{16'h0000, 4'd0,  1'b0, 1'b0, 7'd3}},
        '{ACT_PUSH, 4'd15, 16'hABCD, 1'b1, '{16'h0000, 4'd0,  1'b0, 1'b0, 7'd4}},
        '{ACT_PUSH, 4'd10, 16'h0001, 1'b0, NO_TYPED},
        '{ACT_PUSH, 4'd10, 16'h0002, 1'b0, NO_TYPED},
        '{ACT_PUSH, 4'd1,  16'h5555, 1'b0, NO_TYPED},
        '{ACT_POP,  4'd0,  16'h0000, 1'b1, '{16'hABCD, 4'd15, 1'b0, 1'b0, 7'd6}},
        '{ACT_POP,  4'd15, 16'hFFFF, 1'b0, NO_TYPED},
        '{ACT_POP,  4'd0,  16'h0000, 1'b0, NO_TYPED},
        '{ACT_POP,  4'd7,  16'h3C3C, 1'b0, NO_TYPED},
        '{ACT_PUSH, 4'd12, 16'h00FF, 1'b0, NO_TYPED},
        '{ACT_POP,  4'd0,  16'h0000, 1'b0, NO_TYPED},
        '{ACT_POP,  4'd0,  16'h0000, 1'b0, NO_TYPED},
        '{ACT_POP,  4'd0,  16'h0000, 1'b0, NO_TYPED},
        '{ACT_POP,  4'd0,  16'h0000, 1'b0, NO_TYPED},
        '{ACT_POP,  4'd0,  16'h0000, 1'b1, '{16'h0000, 4'd0,  1'b1, 1'b0, 7'd0}},
        '{ACT_PUSH, 4'd5,  16'h8000, 1'b0, NO_TYPED},
        '{ACT_PUSH, 4'd5,  16'h7FFF, 1'b0, NO_TYPED},
        '{ACT_POP,  4'd0,  16'h0000, 1'b0, NO_TYPED},
        '{ACT_POP,  4'd0,  16'h0000, 1'b0, NO_TYPED}
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // sorted chain: highest severity first, equal severities in arrival order
    function automatic alarm_result_t apply_alarm(input logic act, input logic [SEV_W-1:0] sev,
                                                  input logic [IN_TAG_W-1:0] tag);
        alarm_result_t res;
        alarm_cell_t   entry;
        int            pos;
        res = '0;
        if (act == ACT_PUSH) begin
            if (alarm_chain.size() >= QUEUE_CAP) begin
                res.dropped = 1'b1;
                push_drops++;
            end else begin
                pos = 0;
                while (pos < alarm_chain.size() && alarm_chain[pos].sev >= sev)
                    pos++;
                entry.sev = sev;
                entry.tag = tag & IN_TAG_W'((64'd1 << TAG_WIDTH) - 1);
                alarm_chain.insert(pos, entry);
            end
        end else begin
            if (alarm_chain.size() == 0) begin
                res.empty = 1'b1;
                pops_empty++;
            end else begin
                entry = alarm_chain.pop_front();
                res.tag = entry.tag;
                res.sev = entry.sev;
                pops_hit++;
            end
        end
        res.fill = FILL_W'(alarm_chain.size());
        if (alarm_chain.size() > peak_fill)
            peak_fill = alarm_chain.size();
        return res;
    endfunction

    alarm_result_t predicted;
    alarm_result_t oldest;
    alarm_result_t seen;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                predicted = apply_alarm(in_ch.action, in_ch.severity, in_ch.message_tag);
                pending_results.push_back(cur_has_typed ? cur_typed : predicted);
                beats_in++;
            end
            if (out_ch.valid && out_ch.ready) begin
                seen = '{out_ch.out_tag, out_ch.out_severity, out_ch.was_empty,
                         out_ch.push_dropped, out_ch.fill_count};
                beats_out++;
                if (pending_results.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: result beat %0d with nothing expected", $time, beats_out);
                end else begin
                    oldest = pending_results.pop_front();
                    if (seen.tag !== oldest.tag || seen.sev !== oldest.sev ||
                        seen.empty !== oldest.empty || seen.dropped !== oldest.dropped ||
                        seen.fill !== oldest.fill) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("%0t: beat %0d expected tag=%h sev=%0d empty=%b drop=%b ",
                                     $time, beats_out, oldest.tag, oldest.sev, oldest.empty,
                                     oldest.dropped,
                                     "fill=%0d, got tag=%h sev=%0d empty=%b drop=%b fill=%0d",
                                     oldest.fill, seen.tag, seen.sev, seen.empty,
                                     seen.dropped, seen.fill);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic drive_beat(input logic act, input logic [SEV_W-1:0] sev,
                              input logic [IN_TAG_W-1:0] tag, input logic has_typed,
                              input alarm_result_t typed);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(99) < IDLE_PCT) begin
                in_ch.valid <= 1'b0;
            end else begin
                in_ch.valid       <= 1'b1;
                in_ch.action      <= act;
                in_ch.severity    <= sev;
                in_ch.message_tag <= tag;
                cur_has_typed     <= has_typed;
                cur_typed         <= typed;
                break;
            end
        end
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    function automatic logic [SEV_W-1:0] pick_severity(input int lo, input int hi);
        if ($urandom_range(99) < 10)
            return SEV_W'($urandom_range(15));
        return SEV_W'($urandom_range(hi, lo));
    endfunction

    initial begin
        int sent;
        int push_pct;
        int run_len;
        int sev_lo;
        int sev_hi;
        int waited;
        logic act;

        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_PUSH;
        in_ch.severity    = '0;
        in_ch.message_tag = '0;
        out_ch.ready      = 1'b0;
        cur_has_typed     = 1'b0;
        cur_typed         = NO_TYPED;
        calm              = 1'b0;
        err_count         = 0;
        beats_in          = 0;
        beats_out         = 0;
        pops_hit          = 0;
        pops_empty        = 0;
        push_drops        = 0;
        peak_fill         = 0;
        i_rst_n           = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[k])
            drive_beat(dir_table[k].act, dir_table[k].sev, dir_table[k].tag,
                       dir_table[k].has_typed, dir_table[k].typed);

        // fill past capacity first so full-queue drops show up early
        sent = 0;
        for (int k = 0; k < QUEUE_CAP + 8; k++) begin
            drive_beat(ACT_PUSH, pick_severity(1, 10), IN_TAG_W'($urandom), 1'b0, NO_TYPED);
            sent++;
        end

        while (sent < RAND_ITEMS) begin
            case ($urandom_range(2))
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = 50;
            endcase
            run_len = $urandom_range(80, 20);
            if ($urandom_range(1) == 0) begin
                sev_lo = 1;
                sev_hi = 10;
            end else begin
                sev_lo = $urandom_range(10, 1);
                sev_hi = (sev_lo + 2 > 10) ? 10 : sev_lo + 2;
            end
            for (int k = 0; k < run_len && sent < RAND_ITEMS; k++) begin
                calm = (sent >= 500 && sent < 700);
                act = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP;
                drive_beat(act, pick_severity(sev_lo, sev_hi), IN_TAG_W'($urandom),
                           1'b0, NO_TYPED);
                sent++;
            end
        end
        calm = 1'b0;

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            err_count += pending_results.size();
        end

        $display("%0d commands, %0d results: %0d alarms popped, %0d empty pops, %0d drops",
                 beats_in, beats_out, pops_hit, pops_empty, push_drops);
        $display("highest fill %0d of %0d, %0d mismatches", peak_fill, QUEUE_CAP, err_count);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
